// ===== design/shpc_pkg.sv =====
// ----------------------------------------------------------------------------
// shpc_pkg
// Shared types, codes and constants of the stepper homing position controller.
// ----------------------------------------------------------------------------
package shpc_pkg;

  localparam int PosW = 20;
  localparam int DivW = PosW + 8;
  localparam int CntW = $clog2(DivW);
  localparam logic [PosW-1:0] POS_MAX = '1;

  localparam logic [7:0] CMD_MAX_MOVE = 8'd100;
  localparam logic [7:0] CMD_CAL      = 8'd150;
  localparam logic [7:0] CMD_IDLE     = 8'd200;
  localparam logic [7:0] CMD_CANCEL   = 8'd201;
  localparam logic [7:0] LOC_SPLIT    = 8'd50;

  localparam logic [19:0] FULL_RESET    = 20'd1000;
  localparam logic [19:0] MOFF_RESET    = 20'd60000;
  localparam logic [15:0] REPORT_RESET  = 16'd2000;
  localparam logic [15:0] CORRECT_RESET = 16'd1000;
  localparam logic [6:0] PCT_MAX = 7'd100;
  localparam logic [7:0] PCT_SCALE = 8'd200;

  // divide by 100 as a shift by two and a reciprocal multiply for 25
  localparam int NpShift = DivW + 3;
  localparam longint unsigned NpRecipL = ((64'd1 << NpShift) + 64'd24) / 64'd25;
  localparam logic [DivW-2:0] NP_RECIP = (DivW-1)'(NpRecipL);

  typedef enum logic [1:0] {
    REG_FULL_DEFAULT = 2'd0,
    REG_MOTOR_OFF    = 2'd1,
    REG_REPORT       = 2'd2,
    REG_CORRECT      = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    KIND_TICK   = 3'd0,
    KIND_MOVE   = 3'd1,
    KIND_CAL    = 3'd2,
    KIND_CANCEL = 3'd3,
    KIND_ALARM  = 3'd4,
    KIND_CLEAR  = 3'd5
  } kind_t;

  typedef enum logic [3:0] {
    ST_NONE       = 4'd0,
    ST_ERROR      = 4'd1,
    ST_CANCELLED  = 4'd2,
    ST_LOCK_OPEN  = 4'd3,
    ST_START_CAL  = 4'd4,
    ST_END_CAL    = 4'd5,
    ST_START_FIND = 4'd6,
    ST_START_OPEN = 4'd7,
    ST_END_OPEN   = 4'd8,
    ST_START_CLOSE = 4'd9,
    ST_END_CLOSE  = 4'd10,
    ST_ERR_CLEARED = 4'd11
  } status_t;

  typedef enum logic [1:0] {
    RK_NONE    = 2'd0,
    RK_PCT     = 2'd1,
    RK_UNKNOWN = 2'd2
  } rkind_t;

  typedef enum logic [1:0] {
    RS_NONE  = 2'd0,
    RS_FLOOR = 2'd1,
    RS_ROUND = 2'd2
  } rsel_t;

  typedef enum logic [3:0] {
    PH_START       = 4'd0,
    PH_CAL_CLOSE   = 4'd1,
    PH_CAL_OPEN    = 4'd2,
    PH_LOC_CLOSE   = 4'd3,
    PH_LOC_OPEN    = 4'd4,
    PH_PLAN        = 4'd5,
    PH_MOVE        = 4'd6,
    PH_POST        = 4'd7,
    PH_CREEP_CLOSE = 4'd8,
    PH_CREEP_OPEN  = 4'd9
  } phase_t;

  typedef enum logic [2:0] {
    C_IDLE     = 3'd0,
    C_PREP     = 3'd1,
    C_NP_WAIT  = 3'd2,
    C_EXEC     = 3'd3,
    C_CHECK    = 3'd4,
    C_PCT_WAIT = 3'd5,
    C_OUT      = 3'd6
  } cstate_t;

  typedef struct packed {
    logic accept;
    logic np_start;
    logic np_load;
    logic exec;
    logic pct_start;
    logic pct_load;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic need_pct;
    logic np_done;
    logic div_done;
    logic out_free;
  } dp_sts_t;

endpackage

// ===== design/shpc_div.sv =====
// ----------------------------------------------------------------------------
// shpc_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module shpc_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [shpc_pkg::DivW-1:0]  dividend,
  input  logic [shpc_pkg::PosW-1:0]  divisor,
  output logic                       done,
  output logic [shpc_pkg::DivW-1:0]  quotient
);
  import shpc_pkg::*;

  logic [PosW:0]   rem;
  logic [DivW-1:0] quo;
  logic [PosW-1:0] dvs;
  logic [CntW-1:0] cnt;
  logic            busy;
  logic [PosW:0]   trial;
  logic            ge;

  assign trial    = {rem[PosW-1:0], quo[DivW-1]};
  assign ge       = trial >= {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CntW'(DivW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= ge ? (trial - {1'b0, dvs}) : trial;
      quo <= {quo[DivW-2:0], ge};
    end
  end

endmodule

// ===== design/shpc_dp.sv =====
// ----------------------------------------------------------------------------
// shpc_dp
// Datapath: position state, configuration, step decision and result register.
// ----------------------------------------------------------------------------
module shpc_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  shpc_pkg::ctrl_cmd_t  cmd,
  output shpc_pkg::dp_sts_t    sts,
  input  logic [15:0]          s_axis_tdata,
  input  logic [2:0]           s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [15:0]          m_axis_tdata,
  output logic [1:0]           m_axis_tuser,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_addr,
  input  logic [19:0]          cfg_data
);
  import shpc_pkg::*;

  typedef struct packed {
    logic [19:0] moff;
    logic [15:0] rep;
    logic [15:0] corr;
  } cfg_t;

  typedef struct packed {
    logic [PosW-1:0] pos;
    logic            known;
    logic [PosW-1:0] full;
    logic [7:0]      acmd;
    phase_t          ph;
    logic [PosW-1:0] tgt;
    logic            mopen;
    logic            elock;
    logic            mon;
    logic [19:0]     itmr;
    logic [15:0]     rtmr;
    logic [15:0]     ctmr;
    logic            step;
    logic            sopen;
    status_t         status;
    rkind_t          rkind;
    rsel_t           rsel;
    logic [PosW-1:0] pnum;
    logic [PosW-1:0] pden;
  } st_t;

  cfg_t            cfg;
  st_t             st;
  st_t             st_next;
  logic [2:0]      in_kind;
  logic [6:0]      in_pct;
  logic            in_cl;
  logic            in_op;
  logic            in_lock;
  logic [PosW-1:0] np;
  logic [DivW-1:0] np_prod;
  logic            np_v;
  logic [2*DivW-4:0] np_mul;
  logic [6:0]      rpct;
  logic [6:0]      pct_next;
  logic            div_start;
  logic [DivW-1:0] div_dividend;
  logic [PosW-1:0] div_divisor;
  logic            div_done;
  logic [DivW-1:0] div_q;
  logic [6:0]      cmd_pct;
  logic [DivW-1:0] q_half;
  logic [DivW:0]   q_round;

  function automatic st_t f_idle(st_t s);
    s.acmd = CMD_IDLE;
    s.ph   = PH_START;
    return s;
  endfunction

  function automatic st_t f_off(st_t s);
    s.mon   = 1'b0;
    s.rkind = RK_UNKNOWN;
    s.rsel  = RS_NONE;
    return s;
  endfunction

  function automatic st_t f_step(st_t s, logic open);
    s.step  = 1'b1;
    s.sopen = open;
    if (open && s.pos != POS_MAX) s.pos = s.pos + 1'b1;
    return s;
  endfunction

  function automatic st_t f_finish(st_t s);
    s.rkind  = RK_PCT;
    s.rsel   = RS_ROUND;
    s.status = s.mopen ? ST_END_OPEN : ST_END_CLOSE;
    return f_idle(s);
  endfunction

  function automatic st_t f_plan(st_t s, logic [PosW-1:0] n);
    s.tgt    = n;
    s.rtmr   = '0;
    s.mopen  = n > s.pos;
    s.status = s.mopen ? ST_START_OPEN : ST_START_CLOSE;
    s.ph     = (n == s.pos) ? PH_POST : PH_MOVE;
    return s;
  endfunction

  function automatic st_t f_plan_or_done(st_t s, logic [PosW-1:0] n, logic cl, logic op);
    logic settled;
    settled = (n == s.pos) && ((n == '0 && cl) || (n == s.full && op) ||
                               (n != '0 && n < s.full));
    if (settled) return f_idle(s);
    return f_plan(s, n);
  endfunction

  function automatic st_t f_creep_close(st_t s, logic cl, cfg_t c);
    if (cl || s.ctmr >= c.corr) return f_finish(s);
    s.ctmr = s.ctmr + 1'b1;
    return f_step(s, 1'b0);
  endfunction

  function automatic st_t f_creep_open(st_t s, logic op, cfg_t c);
    if (op) begin
      s.full = s.pos;
      return f_finish(s);
    end
    if (s.ctmr >= c.corr) return f_finish(s);
    s.ctmr = s.ctmr + 1'b1;
    return f_step(s, 1'b1);
  endfunction

  function automatic st_t f_post(st_t s, logic cl, logic op, cfg_t c);
    s.ctmr = '0;
    if (s.pos == '0 && !cl) begin
      s.ph = PH_CREEP_CLOSE;
      return f_creep_close(s, cl, c);
    end
    if (s.pos == s.full && !op) begin
      s.ph = PH_CREEP_OPEN;
      return f_creep_open(s, op, c);
    end
    return f_finish(s);
  endfunction

  function automatic st_t f_cal_open(st_t s, logic op);
    if (!op) return f_step(s, 1'b1);
    s.full   = s.pos;
    s.status = ST_END_CAL;
    if (s.acmd == CMD_CAL || s.full == '0) return f_idle(s);
    s.ph = PH_PLAN;
    return s;
  endfunction

  function automatic st_t f_move(st_t s, logic cl, logic op, cfg_t c);
    logic brk;
    brk = 1'b0;
    if (s.pos == s.tgt) return f_post(s, cl, op, c);
    s.step  = 1'b1;
    s.sopen = s.mopen;
    if (s.mopen && s.pos < s.full) s.pos = s.pos + 1'b1;
    else if (!s.mopen && s.pos != '0) s.pos = s.pos - 1'b1;
    s.rtmr = s.rtmr + 1'b1;
    if (s.rtmr >= c.rep) begin
      s.rtmr  = '0;
      s.rkind = RK_PCT;
      s.rsel  = RS_FLOOR;
      s.pnum  = s.pos;
      s.pden  = s.full;
    end
    if (s.mopen && s.pos != s.full && op) begin
      s.full = s.pos;
      brk    = 1'b1;
    end else if (!s.mopen && s.pos != '0 && cl) begin
      s.pos = '0;
      brk   = 1'b1;
    end
    if (brk || s.pos == s.tgt) s.ph = PH_POST;
    return s;
  endfunction

  function automatic st_t f_run(st_t s, logic [PosW-1:0] n, logic cl, logic op, cfg_t c);
    unique case (s.ph)
      PH_START: begin
        if (s.acmd == CMD_CAL || s.full == '0) begin
          s.status = ST_START_CAL;
          s.ph     = PH_CAL_CLOSE;
        end else if (!s.known) begin
          if (cl) begin
            s.pos = '0;
            s.known = 1'b1;
            s = f_plan_or_done(s, n, cl, op);
          end else if (op) begin
            s.pos = s.full;
            s.known = 1'b1;
            s = f_plan_or_done(s, n, cl, op);
          end else begin
            s.status = ST_START_FIND;
            s.ph     = (s.acmd < LOC_SPLIT) ? PH_LOC_CLOSE : PH_LOC_OPEN;
          end
        end else begin
          s = f_plan_or_done(s, n, cl, op);
        end
      end
      PH_CAL_CLOSE: begin
        if (cl) begin
          s.pos   = '0;
          s.known = 1'b1;
          s.ph    = PH_CAL_OPEN;
          s = f_cal_open(s, op);
        end else begin
          s = f_step(s, 1'b0);
        end
      end
      PH_CAL_OPEN: s = f_cal_open(s, op);
      PH_LOC_CLOSE: begin
        if (cl) begin
          s.pos = '0;
          s.known = 1'b1;
          s = f_plan_or_done(s, n, cl, op);
        end else begin
          s = f_step(s, 1'b0);
        end
      end
      PH_LOC_OPEN: begin
        if (op) begin
          s.pos = s.full;
          s.known = 1'b1;
          s = f_plan_or_done(s, n, cl, op);
        end else begin
          s.step  = 1'b1;
          s.sopen = 1'b1;
        end
      end
      PH_PLAN:        s = f_plan_or_done(s, n, cl, op);
      PH_MOVE:        s = f_move(s, cl, op, c);
      PH_POST:        s = f_post(s, cl, op, c);
      PH_CREEP_CLOSE: s = f_creep_close(s, cl, c);
      PH_CREEP_OPEN:  s = f_creep_open(s, op, c);
      default:        s.ph = PH_START;
    endcase
    return s;
  endfunction

  function automatic st_t f_tick(st_t s, logic [PosW-1:0] n, logic cl, logic op,
                                 logic lock, cfg_t c);
    logic off;
    off = 1'b0;
    if (s.elock) begin
      if (s.acmd != CMD_IDLE) s.status = ST_ERROR;
      s = f_idle(s);
      s.known = 1'b0;
      if (s.mon) s = f_off(s);
      return s;
    end
    if (s.acmd == CMD_IDLE) begin
      s.ph = PH_START;
      if (s.known) begin
        if (s.full != '0 && (s.pos == s.full || s.pos == '0)) begin
          s.itmr = s.itmr + 1'b1;
          if (s.itmr >= c.moff) begin
            s.itmr = '0;
            off = 1'b1;
          end
        end
        if (!lock) off = 1'b1;
        if (off) begin
          s.known = 1'b0;
          s = f_off(s);
        end
      end
      return s;
    end
    s.itmr = '0;
    if (s.acmd == CMD_CANCEL) begin
      s.status = ST_CANCELLED;
      s = f_idle(s);
      if (s.full == '0) s.known = 1'b0;
      if (!s.known) s = f_off(s);
      return s;
    end
    if (!lock) begin
      s.status = ST_LOCK_OPEN;
      s = f_off(s);
      s.known = 1'b0;
      return f_idle(s);
    end
    s.mon = 1'b1;
    return f_run(s, n, cl, op, c);
  endfunction

  function automatic st_t f_set_cmd(st_t s, logic [7:0] v);
    if (s.acmd != v) begin
      s.acmd = v;
      s.ph   = PH_START;
    end
    return s;
  endfunction

  // per-item state update
  always_comb begin
    st_next        = st;
    st_next.step   = 1'b0;
    st_next.sopen  = 1'b0;
    st_next.status = ST_NONE;
    st_next.rkind  = RK_NONE;
    st_next.rsel   = RS_NONE;
    case (kind_t'(in_kind))
      KIND_TICK: st_next = f_tick(st_next, np, in_cl, in_op, in_lock, cfg);
      KIND_MOVE: begin
        if (st_next.elock) st_next.status = ST_ERROR;
        else st_next = f_set_cmd(st_next, {1'b0, cmd_pct});
      end
      KIND_CAL: begin
        st_next.elock = 1'b0;
        st_next = f_set_cmd(st_next, CMD_CAL);
      end
      KIND_CANCEL: begin
        if (st_next.elock) st_next.status = ST_ERROR;
        else st_next = f_set_cmd(st_next, CMD_CANCEL);
      end
      KIND_ALARM: begin
        if (!st_next.elock) begin
          st_next = f_off(st_next);
          st_next.elock = 1'b1;
          st_next = f_set_cmd(st_next, CMD_CANCEL);
        end
      end
      KIND_CLEAR: begin
        st_next.elock  = 1'b0;
        st_next.status = ST_ERR_CLEARED;
      end
      default: ;
    endcase
    if (st_next.rsel == RS_ROUND) begin
      st_next.pnum = st_next.pos;
      st_next.pden = st_next.full;
    end
  end

  assign cmd_pct = (in_pct > PCT_MAX) ? PCT_MAX : in_pct;

  always_ff @(posedge clk) begin
    if (rst) begin
      st.pos    <= '0;
      st.known  <= 1'b0;
      st.full   <= PosW'(FULL_RESET);
      st.acmd   <= CMD_IDLE;
      st.ph     <= PH_START;
      st.tgt    <= '0;
      st.mopen  <= 1'b0;
      st.elock  <= 1'b0;
      st.mon    <= 1'b0;
      st.itmr   <= '0;
      st.rtmr   <= '0;
      st.ctmr   <= '0;
      st.step   <= 1'b0;
      st.sopen  <= 1'b0;
      st.status <= ST_NONE;
      st.rkind  <= RK_NONE;
      st.rsel   <= RS_NONE;
      st.pnum   <= '0;
      st.pden   <= '0;
      cfg.moff  <= MOFF_RESET;
      cfg.rep   <= REPORT_RESET;
      cfg.corr  <= CORRECT_RESET;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_addr))
        REG_FULL_DEFAULT: st.full <= PosW'(cfg_data);
        REG_MOTOR_OFF: cfg.moff <= cfg_data;
        REG_REPORT:    cfg.rep  <= cfg_data[15:0];
        REG_CORRECT:   cfg.corr <= cfg_data[15:0];
        default: ;
      endcase
    end else if (cmd.exec) begin
      st <= st_next;
    end
  end

  // input item capture
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      in_kind <= s_axis_tuser;
      in_pct  <= s_axis_tdata[6:0];
      in_cl   <= s_axis_tdata[7];
      in_op   <= s_axis_tdata[8];
      in_lock <= s_axis_tdata[9];
    end
  end

  // target position: product, then reciprocal multiply for the divide by 100
  assign np_mul = (2*DivW-3)'(np_prod[DivW-1:2]) * (2*DivW-3)'(NP_RECIP);

  always_ff @(posedge clk) begin
    if (rst) np_v <= 1'b0;
    else np_v <= cmd.np_start;
  end

  // report percent on the serial divider
  assign div_start    = cmd.pct_start;
  assign div_dividend = DivW'(st.pnum) * DivW'(PCT_SCALE);
  assign div_divisor  = st.pden;

  shpc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  assign q_half  = {1'b0, div_q[DivW-1:1]};
  assign q_round = ({1'b0, div_q} + 1'b1) >> 1;

  always_comb begin
    if (st.pden == '0) begin
      pct_next = '0;
    end else if (st.rsel == RS_FLOOR) begin
      pct_next = (q_half > DivW'(PCT_MAX)) ? PCT_MAX : q_half[6:0];
    end else begin
      pct_next = (q_round > (DivW + 1)'(PCT_MAX)) ? PCT_MAX : q_round[6:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.np_start)
      np_prod <= DivW'((st.acmd > CMD_MAX_MOVE) ? PCT_MAX : st.acmd[6:0]) * DivW'(st.full);
    if (cmd.np_load) np <= np_mul[NpShift +: PosW];
    if (cmd.exec) rpct <= '0;
    else if (cmd.pct_load) rpct <= pct_next;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_axis_tdata <= {1'b0, st.acmd != CMD_IDLE,
                       (st.rkind == RK_PCT) ? rpct : 7'd0,
                       st.status, st.mon, st.step & st.sopen, st.step};
      m_axis_tuser <= st.rkind;
    end
  end

  assign sts.is_tick  = kind_t'(in_kind) == KIND_TICK;
  assign sts.need_pct = st.rsel != RS_NONE;
  assign sts.np_done  = np_v;
  assign sts.div_done = div_done;
  assign sts.out_free = !m_axis_tvalid || m_axis_tready;

`ifndef NO_ASSERTIONS
  a_idle_phase: assert property (@(posedge clk) disable iff (rst)
    st.acmd == CMD_IDLE |-> st.ph == PH_START)
    else $error("idle command with active phase");
  a_open_step: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (!m_axis_tdata[1] || m_axis_tdata[0]))
    else $error("direction without step");
  a_pct_kind: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser != RK_PCT) |-> m_axis_tdata[13:7] == 7'd0)
    else $error("percent without report");
  a_pct_range: assert property (@(posedge clk) disable iff (rst)
    cmd.pct_load |=> rpct <= PCT_MAX)
    else $error("percent out of range");
`endif

endmodule

// ===== design/shpc_ctrl.sv =====
// ----------------------------------------------------------------------------
// shpc_ctrl
// Controller: sequences capture, target divide, update, report divide, output.
// ----------------------------------------------------------------------------
module shpc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  shpc_pkg::dp_sts_t    sts,
  output shpc_pkg::ctrl_cmd_t  cmd
);
  import shpc_pkg::*;

  cstate_t state;
  cstate_t state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= C_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      C_IDLE:     if (s_axis_tvalid) state_next = C_PREP;
      C_PREP:     state_next = sts.is_tick ? C_NP_WAIT : C_EXEC;
      C_NP_WAIT:  if (sts.np_done) state_next = C_EXEC;
      C_EXEC:     state_next = C_CHECK;
      C_CHECK:    state_next = sts.need_pct ? C_PCT_WAIT : C_OUT;
      C_PCT_WAIT: if (sts.div_done) state_next = C_OUT;
      C_OUT:      if (sts.out_free) state_next = C_IDLE;
      default:    state_next = C_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    s_axis_tready = 1'b0;
    unique case (state)
      C_IDLE: begin
        s_axis_tready = 1'b1;
        cmd.accept    = s_axis_tvalid;
      end
      C_PREP:     cmd.np_start  = sts.is_tick;
      C_NP_WAIT:  cmd.np_load   = sts.np_done;
      C_EXEC:     cmd.exec      = 1'b1;
      C_CHECK:    cmd.pct_start = sts.need_pct;
      C_PCT_WAIT: cmd.pct_load  = sts.div_done;
      C_OUT:      cmd.out_load  = sts.out_free;
      default: ;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_one_start: assert property (@(posedge clk) disable iff (rst)
    !(cmd.np_start && cmd.pct_start))
    else $error("divider started twice");
  a_exec_path: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |-> ($past(state) == C_PREP || $past(state) == C_NP_WAIT))
    else $error("update without capture");
  a_out_after: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> state == C_IDLE)
    else $error("output load did not finish item");
`endif

endmodule

// ===== design/stepper_homing_position_controller.sv =====
// ----------------------------------------------------------------------------
// stepper_homing_position_controller
// Stepper positioning with homing, calibration, endstop correction and reports.
// ----------------------------------------------------------------------------
// One item at a time. A tick item that issues a percent report has its result
// in the output register once the bit-serial divider has produced the 28-bit
// quotient for the percent; the target position is found first (product, then
// reciprocal multiply). A tick without a report skips the divider, and a command
// item skips the target position as well. The next item is taken in the
// cycle after the result is loaded; a result not yet taken holds the load.
module stepper_homing_position_controller (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // percent[6:0], close_endstop, open_endstop, lock_allows
  input  logic [2:0]  s_axis_tuser,   // kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // step_pulse, step_open, motor_power, status[3:0],
                                      // report_percent[6:0], busy_res
  output logic [1:0]  m_axis_tuser,   // report_kind
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [19:0] cfg_data
);
  import shpc_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  shpc_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .sts           (sts),
    .cmd           (cmd)
  );

  shpc_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_data      (cfg_data)
  );

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the stepper homing position controller. A simple
// plant model turns issued step pulses into endstop levels. Every item gets a
// predicted result, and each result is compared field by field in order.
// The run covers several register settings, random idling on the input side
// and random stalls on the output side.
// ----------------------------------------------------------------------------
module tb;
  import shpc_pkg::*;

  typedef struct {
    logic [2:0] kind;
    logic [6:0] pct;
    logic       cl;
    logic       op;
    logic       lk;
  } cmd_item_t;

  typedef struct packed {
    logic       step;
    logic       sopen;
    logic       power;
    logic [3:0] status;
    logic [1:0] rk;
    logic [6:0] rpct;
    logic       busy;
  } step_res_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [15:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        cfg_we = 0;
  logic [1:0]  cfg_addr = '0;
  logic [19:0] cfg_data = '0;

  stepper_homing_position_controller dut (.*);

  always #6 clk = ~clk;

  cmd_item_t pending_q[$];
  step_res_t expect_q[$];
  int        errs = 0;
  int        n_results = 0;
  int        n_steps = 0;
  int        n_reports = 0;

  // controller model state
  logic [19:0] reg_full, reg_moff;
  logic [15:0] reg_rep, reg_corr;
  logic [19:0] pos, full, tgt, idle_t;
  logic [15:0] rep_t, creep_t;
  logic [7:0]  cmd;
  phase_t      ph;
  logic        known, mv_open, err_lk, mon;
  step_res_t   r;

  // plant
  int phys, span;

  function automatic logic [6:0] pct_of(logic rounded);
    longint unsigned p;
    if (full == 0) return 0;
    if (rounded) p = ((longint'(pos) * 200) / full + 1) / 2;
    else p = (longint'(pos) * 100) / full;
    return (p > 100) ? PCT_MAX : 7'(p);
  endfunction

  function automatic void power_down();
    mon = 0;
    r.rk = RK_UNKNOWN;
    r.rpct = 0;
  endfunction

  function automatic void to_idle();
    cmd = CMD_IDLE;
    ph = PH_START;
  endfunction

  function automatic void step_out(logic dir);
    r.step = 1;
    r.sopen = dir;
    if (dir && pos != POS_MAX) pos++;
  endfunction

  function automatic void finish_move();
    r.rk = RK_PCT;
    r.rpct = pct_of(1);
    r.status = mv_open ? ST_END_OPEN : ST_END_CLOSE;
    to_idle();
  endfunction

  function automatic logic [19:0] new_target();
    longint unsigned p, np;
    p = (cmd > CMD_MAX_MOVE) ? CMD_MAX_MOVE : cmd;
    np = (p * full) / 100;
    return 20'(np);
  endfunction

  function automatic void plan_or_done(logic cl, logic op);
    logic [19:0] np;
    np = new_target();
    if (np == pos && ((np == 0 && cl) || (np == full && op) || (np > 0 && np < full))) begin
      to_idle();
      return;
    end
    if (np > full) np = full;
    tgt = np;
    rep_t = 0;
    mv_open = np > pos;
    r.status = mv_open ? ST_START_OPEN : ST_START_CLOSE;
    ph = (np == pos) ? PH_POST : PH_MOVE;
  endfunction

  function automatic void creep_close(logic cl);
    if (cl || creep_t >= reg_corr) begin
      finish_move();
      return;
    end
    creep_t++;
    step_out(0);
  endfunction

  function automatic void creep_open(logic op);
    if (op) begin
      full = pos;
      finish_move();
      return;
    end
    if (creep_t >= reg_corr) begin
      finish_move();
      return;
    end
    creep_t++;
    step_out(1);
  endfunction

  function automatic void post_move(logic cl, logic op);
    creep_t = 0;
    if (pos == 0 && !cl) begin
      ph = PH_CREEP_CLOSE;
      creep_close(cl);
    end else if (pos == full && !op) begin
      ph = PH_CREEP_OPEN;
      creep_open(op);
    end else begin
      finish_move();
    end
  endfunction

  function automatic void cal_open(logic op);
    if (!op) begin
      step_out(1);
      return;
    end
    full = pos;
    r.status = ST_END_CAL;
    if (cmd == CMD_CAL || full == 0) to_idle();
    else ph = PH_PLAN;
  endfunction

  function automatic void move_tick(logic cl, logic op);
    logic brk;
    brk = 0;
    if (pos == tgt) begin
      post_move(cl, op);
      return;
    end
    r.step = 1;
    r.sopen = mv_open;
    if (mv_open && pos < full) pos++;
    else if (!mv_open && pos > 0) pos--;
    rep_t = rep_t + 16'd1;
    if (rep_t >= reg_rep) begin
      rep_t = 0;
      r.rk = RK_PCT;
      r.rpct = pct_of(0);
    end
    if (mv_open && pos != full && op) begin
      full = pos;
      brk = 1;
    end else if (!mv_open && pos != 0 && cl) begin
      pos = 0;
      brk = 1;
    end
    if (brk || pos == tgt) ph = PH_POST;
  endfunction

  function automatic void run_phase(logic cl, logic op);
    case (ph)
      PH_START: begin
        if (cmd == CMD_CAL || full == 0) begin
          r.status = ST_START_CAL;
          ph = PH_CAL_CLOSE;
        end else if (!known) begin
          if (cl) begin
            pos = 0; known = 1; plan_or_done(cl, op);
          end else if (op) begin
            pos = full; known = 1; plan_or_done(cl, op);
          end else begin
            r.status = ST_START_FIND;
            ph = (cmd < LOC_SPLIT) ? PH_LOC_CLOSE : PH_LOC_OPEN;
          end
        end else begin
          plan_or_done(cl, op);
        end
      end
      PH_CAL_CLOSE: begin
        if (cl) begin
          pos = 0; known = 1; ph = PH_CAL_OPEN; cal_open(op);
        end else begin
          step_out(0);
        end
      end
      PH_CAL_OPEN: cal_open(op);
      PH_LOC_CLOSE: begin
        if (cl) begin
          pos = 0; known = 1; plan_or_done(cl, op);
        end else begin
          step_out(0);
        end
      end
      PH_LOC_OPEN: begin
        if (op) begin
          pos = full; known = 1; plan_or_done(cl, op);
        end else begin
          r.step = 1; r.sopen = 1;
        end
      end
      PH_PLAN: plan_or_done(cl, op);
      PH_MOVE: move_tick(cl, op);
      PH_POST: post_move(cl, op);
      PH_CREEP_CLOSE: creep_close(cl);
      PH_CREEP_OPEN: creep_open(op);
      default: ph = PH_START;
    endcase
  endfunction

  function automatic void do_tick(logic cl, logic op, logic lk);
    logic off;
    if (err_lk) begin
      if (cmd != CMD_IDLE) r.status = ST_ERROR;
      to_idle();
      known = 0;
      if (mon) power_down();
      return;
    end
    if (cmd == CMD_IDLE) begin
      ph = PH_START;
      if (known) begin
        off = 0;
        if (full != 0 && (pos == full || pos == 0)) begin
          idle_t = idle_t + 20'd1;
          if (idle_t >= reg_moff) begin
            idle_t = 0; off = 1;
          end
        end
        if (!lk) off = 1;
        if (off) begin
          known = 0; power_down();
        end
      end
      return;
    end
    idle_t = 0;
    if (cmd == CMD_CANCEL) begin
      r.status = ST_CANCELLED;
      to_idle();
      if (full == 0) known = 0;
      if (!known) power_down();
      return;
    end
    if (!lk) begin
      r.status = ST_LOCK_OPEN;
      power_down();
      known = 0;
      to_idle();
      return;
    end
    mon = 1;
    run_phase(cl, op);
  endfunction

  function automatic void set_cmd(logic [7:0] c);
    if (cmd != c) begin
      cmd = c;
      ph = PH_START;
    end
  endfunction

  function automatic step_res_t predict_item(cmd_item_t it);
    logic [7:0] p;
    r = '{default: 0};
    p = (it.pct > CMD_MAX_MOVE) ? CMD_MAX_MOVE : {1'b0, it.pct};
    case (it.kind)
      KIND_TICK: do_tick(it.cl, it.op, it.lk);
      KIND_MOVE: if (err_lk) r.status = ST_ERROR; else set_cmd(p);
      KIND_CAL: begin
        err_lk = 0;
        set_cmd(CMD_CAL);
      end
      KIND_CANCEL: if (err_lk) r.status = ST_ERROR; else set_cmd(CMD_CANCEL);
      KIND_ALARM: if (!err_lk) begin
        power_down();
        err_lk = 1;
        set_cmd(CMD_CANCEL);
      end
      KIND_CLEAR: begin
        err_lk = 0;
        r.status = ST_ERR_CLEARED;
      end
      default: ;
    endcase
    if (!r.step) r.sopen = 0;
    r.power = mon;
    if (r.rk != RK_PCT) r.rpct = 0;
    r.busy = (cmd != CMD_IDLE);
    return r;
  endfunction

  task automatic push_item(logic [2:0] k, logic [6:0] p, logic cl, logic op, logic lk);
    cmd_item_t it;
    step_res_t e;
    it = '{kind: k, pct: p, cl: cl, op: op, lk: lk};
    e = predict_item(it);
    pending_q.push_back(it);
    expect_q.push_back(e);
    if (e.step) begin
      if (e.sopen) phys = (phys < span + 2) ? phys + 1 : phys;
      else phys = (phys > 0) ? phys - 1 : 0;
    end
  endtask

  task automatic write_reg(reg_idx_t a, logic [19:0] v);
    @(negedge clk);
    cfg_we = 1;
    cfg_addr = a;
    cfg_data = v;
    @(negedge clk);
    cfg_we = 0;
    case (a)
      REG_FULL_DEFAULT: begin
        reg_full = v; full = v;
      end
      REG_MOTOR_OFF: reg_moff = v;
      REG_REPORT: reg_rep = v[15:0];
      REG_CORRECT: reg_corr = v[15:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_q.size() != 0 || expect_q.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic random_items(int n);
    int u;
    logic cl, op;
    for (int i = 0; i < n; i++) begin
      u = $urandom_range(0, 99);
      if (err_lk && u < 40) begin
        push_item(($urandom_range(0, 1) != 0) ? KIND_CLEAR : KIND_CAL, 7'($urandom), 0, 0, 1);
      end else if (u < 4) begin
        push_item(KIND_MOVE, 7'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
      end else if (u < 6) begin
        push_item(KIND_MOVE, ($urandom_range(0, 1) != 0) ? 7'd100 : 7'd0, 0, 0, 1);
      end else if (u < 7) begin
        push_item(KIND_CAL, 7'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
      end else if (u < 8) begin
        push_item(($urandom_range(0, 3) == 0) ? KIND_ALARM : KIND_CANCEL, 7'($urandom),
                  0, 0, 1);
      end else if (u < 9) begin
        push_item(3'($urandom_range(5, 7)), 7'($urandom), 1'($urandom), 1'($urandom),
                  1'($urandom));
      end else begin
        cl = (phys <= 0);
        op = (phys >= span);
        if ($urandom_range(0, 49) == 0) cl = ~cl;
        if ($urandom_range(0, 49) == 0) op = ~op;
        push_item(KIND_TICK, 7'($urandom), cl, op, $urandom_range(0, 79) != 0);
      end
    end
  endtask

  // driver: bursts with random gaps
  logic taken = 0;
  int   burst_left = 4;
  int   gap_left = 0;

  always @(negedge clk) begin
    cmd_item_t it;
    if (rst) begin
      s_axis_tvalid <= 0;
    end else if (!s_axis_tvalid || taken) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        s_axis_tvalid <= 0;
      end else if (pending_q.size() != 0) begin
        it = pending_q.pop_front();
        s_axis_tvalid <= 1;
        s_axis_tdata <= {6'd0, it.lk, it.op, it.cl, it.pct};
        s_axis_tuser <= it.kind;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 12);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_axis_tvalid <= 0;
      end
    end
  end

  // receiver stall pattern
  int stall_mode = 0;
  int mode_left = 0;

  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 2);
        mode_left <= $urandom_range(50, 600);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: m_axis_tready <= 1;
        1: m_axis_tready <= $urandom_range(0, 1);
        default: m_axis_tready <= ($urandom_range(0, 15) == 0);
      endcase
    end
  end

  // monitor
  always @(posedge clk) begin
    step_res_t e, got;
    taken <= s_axis_tvalid && s_axis_tready;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.step = m_axis_tdata[0];
      got.sopen = m_axis_tdata[1];
      got.power = m_axis_tdata[2];
      got.status = m_axis_tdata[6:3];
      got.rpct = m_axis_tdata[13:7];
      got.busy = m_axis_tdata[14];
      got.rk = m_axis_tuser;
      n_results++;
      if (expect_q.size() == 0) begin
        errs++;
        if (errs <= 10) $display("unexpected result tdata=%h tuser=%0d", m_axis_tdata, m_axis_tuser);
      end else begin
        e = expect_q.pop_front();
        if (e.step) n_steps++;
        if (e.rk == RK_PCT) n_reports++;
        if (got != e) begin
          errs++;
          if (errs <= 10)
            $display("mismatch item %0d: exp step=%b dir=%b pwr=%b st=%0d rk=%0d pct=%0d busy=%b",
                     n_results, e.step, e.sopen, e.power, e.status, e.rk, e.rpct, e.busy,
                     "\n  got step=%b dir=%b pwr=%b st=%0d rk=%0d pct=%0d busy=%b",
                     got.step, got.sopen, got.power, got.status, got.rk, got.rpct, got.busy);
        end
      end
    end
  end

  initial begin
    #(12 * 4000000);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    reg_full = FULL_RESET; reg_moff = MOFF_RESET;
    reg_rep = REPORT_RESET; reg_corr = CORRECT_RESET;
    pos = 0; known = 0; full = FULL_RESET; cmd = CMD_IDLE; ph = PH_START;
    tgt = 0; mv_open = 0; err_lk = 0; mon = 0; idle_t = 0; rep_t = 0; creep_t = 0;
    phys = 3; span = 10;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed
    write_reg(REG_FULL_DEFAULT, 20'd10);
    write_reg(REG_REPORT, 20'd1);
    push_item(KIND_ALARM, 0, 0, 0, 1);
    push_item(KIND_TICK, 0, 0, 0, 1);
    push_item(KIND_MOVE, 7'd50, 0, 0, 1);
    push_item(KIND_CANCEL, 0, 0, 0, 1);
    push_item(KIND_CLEAR, 0, 0, 0, 1);
    push_item(3'd6, 7'd127, 1, 1, 1);
    push_item(3'd7, 0, 0, 0, 0);
    push_item(KIND_CAL, 0, 0, 0, 1);
    push_item(KIND_CAL, 0, 0, 0, 1);
    push_item(KIND_TICK, 0, 1, 1, 1);
    push_item(KIND_TICK, 0, 1, 1, 1);
    push_item(KIND_MOVE, 7'd127, 1, 1, 1);
    push_item(KIND_TICK, 0, 1, 0, 1);
    push_item(KIND_TICK, 0, 1, 0, 1);
    push_item(KIND_TICK, 0, 0, 0, 0);
    push_item(KIND_MOVE, 7'd0, 0, 0, 1);
    push_item(KIND_TICK, 0, 0, 1, 1);
    push_item(KIND_CANCEL, 0, 0, 0, 1);
    push_item(KIND_TICK, 0, 0, 1, 1);
    push_item(KIND_TICK, 0, 0, 1, 0);
    drain();

    for (int k = 0; k < 7; k++) begin
      span = $urandom_range(4, 40);
      phys = $urandom_range(0, span);
      case (k)
        1: begin
          write_reg(REG_FULL_DEFAULT, 20'd20); write_reg(REG_MOTOR_OFF, 20'd1);
          write_reg(REG_REPORT, 20'd1); write_reg(REG_CORRECT, 20'd1);
        end
        2: begin
          write_reg(REG_FULL_DEFAULT, 20'd0); write_reg(REG_MOTOR_OFF, 20'd50);
          write_reg(REG_REPORT, 20'd3); write_reg(REG_CORRECT, 20'd5);
        end
        3: begin
          write_reg(REG_FULL_DEFAULT, 20'hFFFFF); write_reg(REG_MOTOR_OFF, 20'hFFFFF);
          write_reg(REG_REPORT, 20'hFFFF); write_reg(REG_CORRECT, 20'hFFFF);
        end
        4: begin
          write_reg(REG_FULL_DEFAULT, 20'd37); write_reg(REG_MOTOR_OFF, 20'd200);
          write_reg(REG_REPORT, 20'd7); write_reg(REG_CORRECT, 20'hFFFF);
        end
        5: begin
          write_reg(REG_FULL_DEFAULT, 20'd8); write_reg(REG_MOTOR_OFF, 20'd30);
          write_reg(REG_REPORT, 20'd2); write_reg(REG_CORRECT, 20'd3);
        end
        6: begin
          write_reg(REG_FULL_DEFAULT, 20'($urandom_range(1, 60)));
          write_reg(REG_MOTOR_OFF, 20'($urandom_range(1, 400)));
          write_reg(REG_REPORT, 20'($urandom_range(1, 9)));
          write_reg(REG_CORRECT, 20'($urandom_range(1, 20)));
        end
        default: ;
      endcase
      random_items(150);
      drain();
    end

    $display("results checked: %0d, step pulses: %0d, percent reports: %0d",
             n_results, n_steps, n_reports);
    $display("seven register settings incl. zero and full-scale values, random stalls");
    if (errs == 0 && expect_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
design/shpc_pkg.sv
design/shpc_div.sv
design/shpc_dp.sv
design/shpc_ctrl.sv
design/stepper_homing_position_controller.sv
bench/tb.sv
